// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, switched off while reset is low.
`define PCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("polygon centroid core: assertion failed");
// Clocked assertion that also holds during reset.
`define PCA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("polygon centroid core: assertion failed");
`else
`define PCA_ASSERT(label, clk, rst_n, prop)
`define PCA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/pca_pkg.sv -----
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants of the polygon centroid and area core.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CrossW = 44;
  localparam int unsigned WsumW  = 60;
  localparam int unsigned AreaW  = 35;
  localparam int unsigned EdgeW  = 33;  // one cross term
  localparam int unsigned MulAW  = 17;
  localparam int unsigned ProdW  = MulAW + EdgeW;
  localparam int unsigned DivW   = 46;  // magnitude of three times cross sum
  localparam int unsigned DivCntW = $clog2(WsumW + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_CLOSE,
    ST_DSX, ST_DX, ST_DSY, ST_DY, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MS_P1, MS_C, MS_WX, MS_WY
  } mstep_e;

  typedef enum logic {
    AX_X, AX_Y
  } axis_e;

  typedef struct packed {
    logic   load_in;
    logic   mul_en;
    mstep_e mstep;
    logic   load_close;
    logic   div_start;
    logic   div_step;
    axis_e  axis;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/pca_if.sv -----
// ----------------------------------------------------------------------------
// pca_if
// Valid/ready channels for vertex beats and result beats.
// ----------------------------------------------------------------------------
interface pca_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic               last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pca_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] centroid_x;
  logic signed [15:0] centroid_y;
  logic signed [34:0] signed_area;
  logic               degenerate;
  logic               too_many_vertices;
  modport source (output valid, centroid_x, centroid_y, signed_area, degenerate,
                  too_many_vertices, input ready);
  modport sink   (input valid, centroid_x, centroid_y, signed_area, degenerate,
                  too_many_vertices, output ready);
endinterface

// ----- rtl/core/pca_ctrl.sv -----
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer: accept, edge multiply steps, closing edge, division, hand-off.
// ----------------------------------------------------------------------------
module pca_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  pca_pkg::sts_t  sts_i,
  output pca_pkg::cmd_t  cmd_o
);
  import pca_pkg::*;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   close_q, close_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      close_q <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      close_q <= close_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    close_d    = close_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mstep = MS_P1;
    cmd_o.axis  = AX_X;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          last_d  = in_last_i;
          close_d = 1'b0;
          if (!sts_i.count_zero) begin
            state_d = ST_M1;
          end else if (in_last_i) begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_M1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mstep  = MS_P1;
        state_d = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mstep  = MS_C;
        state_d = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mstep  = MS_WX;
        state_d = ST_M4;
      end
      ST_M4: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mstep  = MS_WY;
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!close_q) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_DSX;
        end
      end
      ST_CLOSE: begin
        cmd_o.load_close = 1'b1;
        close_d = 1'b1;
        state_d = ST_M1;
      end
      ST_DSX: begin
        cmd_o.div_start = 1'b1;
        cmd_o.axis = AX_X;
        state_d = ST_DX;
      end
      ST_DX: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DSY;
      end
      ST_DSY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.axis = AX_Y;
        state_d = ST_DY;
      end
      ST_DY: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          close_d = 1'b0;
          last_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/pca_dp.sv -----
// ----------------------------------------------------------------------------
// pca_dp
// Datapath: ring registers, shared multiplier, accumulators, serial divider
// and the result register.
// ----------------------------------------------------------------------------
module pca_dp #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  pca_pkg::cmd_t      cmd_i,
  output pca_pkg::sts_t      sts_o,
  pca_res_if.source          res_o
);
  import pca_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_VERTICES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_VERTICES);
  localparam logic signed [CrossW-1:0] AreaHi = CrossW'((64'sd1 <<< (AreaW - 1)) - 1);
  localparam logic signed [CrossW-1:0] AreaLo = CrossW'(-(64'sd1 <<< (AreaW - 1)));

  logic signed [CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [CntW-1:0]          count_q;
  logic signed [CrossW-1:0] cross_q;
  logic signed [WsumW-1:0]  wsx_q, wsy_q;
  logic signed [EdgeW-1:0]  p_q, c_q;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [EdgeW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;

  // Shared multiplier operand selection
  always_comb begin
    unique case (cmd_i.mstep)
      MS_P1: begin
        mul_a = MulAW'(by_q);
        mul_b = EdgeW'(ax_q);
      end
      MS_C: begin
        mul_a = MulAW'(ay_q);
        mul_b = EdgeW'(bx_q);
      end
      MS_WX: begin
        mul_a = MulAW'(ax_q) + MulAW'(bx_q);
        mul_b = c_q;
      end
      default: begin
        mul_a = MulAW'(ay_q) + MulAW'(by_q);
        mul_b = c_q;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  // Ring registers and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cross_q <= '0;
      wsx_q   <= '0;
      wsy_q   <= '0;
    end else begin
      if (cmd_i.load_in && (count_q != CntSat)) count_q <= count_q + 1'b1;
      if (cmd_i.mul_en) begin
        unique case (cmd_i.mstep)
          MS_C:    cross_q <= cross_q + CrossW'(p_q - EdgeW'(prod));
          MS_WX:   wsx_q   <= wsx_q + WsumW'(prod);
          MS_WY:   wsy_q   <= wsy_q + WsumW'(prod);
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        count_q <= '0;
        cross_q <= '0;
        wsx_q   <= '0;
        wsy_q   <= '0;
      end
    end
  end

  // Vertex and operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ax_q     <= prev_x_q;
      ay_q     <= prev_y_q;
      bx_q     <= vertex_x_i;
      by_q     <= vertex_y_i;
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
      if (count_q == '0) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
      end
    end
    if (cmd_i.load_close) begin
      ax_q <= bx_q;
      ay_q <= by_q;
      bx_q <= first_x_q;
      by_q <= first_y_q;
    end
    if (cmd_i.mul_en && cmd_i.mstep == MS_P1) p_q <= EdgeW'(prod);
    if (cmd_i.mul_en && cmd_i.mstep == MS_C)  c_q <= p_q - EdgeW'(prod);
  end

  // Restoring divider, one quotient bit a cycle
  logic [DivW-1:0]         rem_q, dmag_q;
  logic [WsumW-1:0]        quo_q;
  logic [DivCntW-1:0]      dcnt_q;
  logic                    neg_q;
  axis_e                   axis_q;
  logic signed [CoordW-1:0] cx_q, cy_q;

  logic signed [WsumW-1:0] dvd;
  logic signed [DivW-1:0]  dsr;
  logic [DivW:0]           trial;
  logic                    ge;
  logic [DivW-1:0]         rem_n;
  logic [WsumW-1:0]        quo_n;
  logic signed [CoordW-1:0] qsat;

  assign dvd = (cmd_i.axis == AX_X) ? wsx_q : wsy_q;
  assign dsr = DivW'(cross_q) + (DivW'(cross_q) <<< 1);

  always_comb begin
    trial = {rem_q, quo_q[WsumW-1]};
    ge    = trial >= {1'b0, dmag_q};
    rem_n = ge ? DivW'(trial - {1'b0, dmag_q}) : DivW'(trial);
    quo_n = {quo_q[WsumW-2:0], ge};
    // Saturate the signed quotient to coordinate range
    if (neg_q) begin
      if (quo_n > WsumW'(32768)) qsat = -16'sd32768;
      else                       qsat = CoordW'(-quo_n);
    end else begin
      if (quo_n > WsumW'(32767)) qsat = 16'sd32767;
      else                       qsat = CoordW'(quo_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DivCntW'(WsumW);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= dvd[WsumW-1] ? WsumW'(-dvd) : WsumW'(dvd);
      dmag_q <= dsr[DivW-1] ? DivW'(-dsr) : DivW'(dsr);
      neg_q  <= dvd[WsumW-1] ^ dsr[DivW-1];
      axis_q <= cmd_i.axis;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (dcnt_q == DivCntW'(1)) begin
        if (axis_q == AX_X) cx_q <= qsat;
        else                cy_q <= qsat;
      end
    end
  end

  // Area: floor shift and saturate
  logic signed [CrossW-1:0] area_sh;
  logic signed [AreaW-1:0]  area_sat;
  logic                     degen;

  assign area_sh = cross_q >>> (FRAC_BITS + 1);
  assign degen   = (cross_q == '0);

  always_comb begin
    if (area_sh > AreaHi)      area_sat = AreaW'(AreaHi);
    else if (area_sh < AreaLo) area_sat = AreaW'(AreaLo);
    else                       area_sat = AreaW'(area_sh);
  end

  // Result register: hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.valid <= 1'b0;
    end else if (cmd_i.finish) begin
      res_o.valid <= 1'b1;
    end else if (res_o.ready) begin
      res_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_o.centroid_x        <= degen ? '0 : cx_q;
      res_o.centroid_y        <= degen ? '0 : cy_q;
      res_o.signed_area       <= area_sat;
      res_o.degenerate        <= degen;
      res_o.too_many_vertices <= count_q > CntMax;
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.div_last   = (dcnt_q == DivCntW'(1));
  assign sts_o.out_busy   = res_o.valid && !res_o.ready;

endmodule

// ----- rtl/core/polygon_centroid_area.sv -----
// ----------------------------------------------------------------------------
// polygon_centroid_area
// Shoelace centroid and signed area of a polygon ring, one vertex a beat.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  vtx_i    in   vertex_x, vertex_y, last_vertex
//  res_o    out  centroid_x, centroid_y, signed_area, degenerate, too_many_vertices
//
// The first vertex of a ring is only accepted; each later vertex is accepted and then
// takes four steps of the one shared 17x33 multiplier. The last vertex adds the closing
// edge and two 60-step serial divisions before the result.
// Reset clears the ring state and drops any pending result.
// A waiting result beat stalls only the final hand-off; new vertices are taken.
// ----------------------------------------------------------------------------
module polygon_centroid_area #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pca_vtx_if.sink   vtx_i,
  pca_res_if.source res_o
);
  import pca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_last_i  (vtx_i.last_vertex),
    .in_ready_o (vtx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pca_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vertex_x_i (vtx_i.vertex_x),
    .vertex_y_i (vtx_i.vertex_y),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

`include "assert_macros.svh"

  // Multiplier and divider never run together
  `PCA_ASSERT(a_mul_div_excl, clk_i, rst_ni, !(cmd.mul_en && cmd.div_step))
  // A result beat appears only after the hand-off command
  `PCA_ASSERT(a_res_after_finish, clk_i, rst_ni, $rose(res_o.valid) |-> $past(cmd.finish))
  // Hand-off never overwrites a beat still waiting
  `PCA_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd.finish |-> !(res_o.valid && !res_o.ready))
  // No vertex is taken while the multiplier is busy
  `PCA_ASSERT_ALWAYS(a_load_idle, clk_i, !(cmd.load_in && cmd.mul_en))

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polygon_centroid_area. Rings of vertices are sent
// over the vertex channel with random idling. An in-bench shoelace predictor
// forms the expected centroid, area and flags, and every result beat is
// compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [34:0] area;
    logic               degen;
    logic               over;
  } ring_result_t;

  localparam int unsigned MaxVerts  = 1024;
  localparam int unsigned FracBits  = 8;
  localparam int          StallLimit = 5000;

  logic clk_i;
  logic rst_ni;

  pca_vtx_if vtx();
  pca_res_if res();

  polygon_centroid_area #(
    .MAX_VERTICES(MaxVerts),
    .FRAC_BITS   (FracBits)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx),
    .res_o (res)
  );

  // Shoelace state of the ring under construction
  logic signed [15:0] ring_fx, ring_fy, ring_px, ring_py;
  logic [43:0]        ring_cross;
  logic [59:0]        ring_wx, ring_wy;
  int unsigned        ring_count;

  ring_result_t pending_rings[$];
  int           mismatches;
  bit           idle_on;
  bit           hold_req;
  bit           run_done;
  int           quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clear the predictor ring state
  task automatic ring_clear();
    ring_fx = '0; ring_fy = '0; ring_px = '0; ring_py = '0;
    ring_cross = '0; ring_wx = '0; ring_wy = '0;
    ring_count = 0;
  endtask

  // Accumulate one edge into the cross and weighted sums
  task automatic ring_edge(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] bx, logic signed [15:0] by);
    longint x1, y1, x2, y2, c;
    x1 = ax; y1 = ay; x2 = bx; y2 = by;
    c = y2 * x1 - y1 * x2;
    ring_cross = ring_cross + 44'(c);
    ring_wx    = ring_wx + 60'((x1 + x2) * c);
    ring_wy    = ring_wy + 60'((y1 + y2) * c);
  endtask

  function automatic logic signed [15:0] sat16(longint v);
    if (v < -32768) return -16'sd32768;
    if (v > 32767) return 16'sd32767;
    return 16'(v);
  endfunction

  // Predict the effect of one accepted vertex
  task automatic ring_predict(logic signed [15:0] x, logic signed [15:0] y, logic last);
    ring_result_t r;
    longint cs, sx, sy, d, a;
    if (ring_count == 0) begin
      ring_fx = x; ring_fy = y;
    end else begin
      ring_edge(ring_px, ring_py, x, y);
    end
    ring_px = x; ring_py = y;
    if (ring_count < MaxVerts + 1) ring_count++;
    if (last) begin
      ring_edge(x, y, ring_fx, ring_fy);
      cs = $signed(ring_cross);
      sx = $signed(ring_wx);
      sy = $signed(ring_wy);
      r.degen = (cs == 0);
      r.over  = (ring_count > MaxVerts);
      r.cx = '0; r.cy = '0;
      if (!r.degen) begin
        d = 3 * cs;
        r.cx = sat16(sx / d);
        r.cy = sat16(sy / d);
      end
      a = cs >>> (FracBits + 1);
      if (a < -(64'sd1 <<< 34)) a = -(64'sd1 <<< 34);
      if (a > (64'sd1 <<< 34) - 1) a = (64'sd1 <<< 34) - 1;
      r.area = 35'(a);
      pending_rings.push_back(r);
      ring_clear();
    end
  endtask

  // Offer one vertex beat, idling first at random, and hold until accepted
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
    if (idle_on && ($urandom_range(0, 3) == 0)) begin
      vtx.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    vtx.valid       <= 1'b1;
    vtx.vertex_x    <= x;
    vtx.vertex_y    <= y;
    vtx.last_vertex <= last;
    do @(posedge clk_i); while (!vtx.ready);
    ring_predict(x, y, last);
  endtask

  task automatic send_ring(int n, int mag);
    for (int i = 0; i < n; i++) begin
      send_vertex(16'($signed($urandom_range(0, 2 * mag)) - mag),
                  16'($signed($urandom_range(0, 2 * mag)) - mag), i == n - 1);
    end
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    wait (pending_rings.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  // Extremes, single and two-vertex rings, zero and tiny areas
  task automatic test_directed();
    send_vertex(16'sd100, -16'sd50, 1'b1);
    send_vertex(-16'sd32768, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b1);
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd20, 16'sd20, 1'b1);
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 1'b1);
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b1);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(-16'sd1, 16'sd5, 1'b1);
    drain();
  endtask

  // Ring longer than the vertex bound
  task automatic test_vertex_overflow();
    send_ring(MaxVerts + 6, 32767);
    drain();
  endtask

  // Long receiver hold-off while rings keep arriving
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_ring(3, 32767);
    drain();
  endtask

  // Random rings, mostly small, some wide-range; the last stretch has no idling
  task automatic test_random_rings();
    int sent;
    int n;
    sent = 0;
    while (sent < 460) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      if (sent > 370) idle_on = 1'b0;
      send_ring(n, ($urandom_range(0, 1) == 0) ? 32767 : $urandom_range(1, 300));
      sent += n;
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && ($urandom_range(0, 2) == 0)) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    ring_result_t want, got;
    if (res.valid && res.ready) begin
      got = '{res.centroid_x, res.centroid_y, res.signed_area,
              res.degenerate, res.too_many_vertices};
      if (pending_rings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_rings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (res.valid && res.ready) || !rst_ni ||
        (!vtx.valid && pending_rings.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit && !run_done) begin
        $display("polygon_centroid_area: mismatch");
        $finish;
      end
    end
  end

  // Sequence the tests
  initial begin
    mismatches   = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    run_done     = 1'b0;
    quiet_cycles = 0;
    ring_clear();
    rst_ni          = 1'b0;
    vtx.valid       = 1'b0;
    vtx.vertex_x    = '0;
    vtx.vertex_y    = '0;
    vtx.last_vertex = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_vertex_overflow();
    test_backpressure();
    test_random_rings();
    drain();
    run_done = 1'b1;
    if (mismatches == 0 && pending_rings.size() == 0) begin
      $display("polygon_centroid_area: match");
    end else begin
      $display("polygon_centroid_area: mismatch");
    end
    $finish;
  end
endmodule
